>>> design/cmst_pkg.sv
// shared types, constants and status codes for the counting multiset table
package cmst_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int COUNT_BITS_DEF = 16;

  localparam int KEY_W    = 32;
  localparam int AMOUNT_W = 16;
  localparam int NCOUNT_W = 16;

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_REM = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_SAT    = 2'd3
  } status_t;

  // search token walking down the cell chain
  typedef struct packed {
    logic valid;
    logic hit;
    logic free;
  } tok_t;

  // broadcast write command
  typedef struct packed {
    logic en;
    logic claim;
  } wr_t;

endpackage

>>> design/cmst_cell.sv
// one table slot: key, count, match and free-slot claim logic
module cmst_cell import cmst_pkg::*; #(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [KEY_BITS-1:0]   item_key,
  input  tok_t                  tok_in,
  input  logic [COUNT_BITS-1:0] tcnt_in,
  output tok_t                  tok_out,
  output logic [COUNT_BITS-1:0] tcnt_out,
  input  wr_t                   wr,
  input  logic [KEY_BITS-1:0]   wr_key,
  input  logic [COUNT_BITS-1:0] wr_count
);

  logic [KEY_BITS-1:0]   key_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] tcnt_r;
  tok_t                  tok_r;
  tok_t                  tok_nxt;
  logic                  hit_r;
  logic                  cand_r;
  logic                  occ;
  logic                  match;
  logic                  sel;

  assign occ   = (count_r != '0);
  assign match = occ && (key_r == item_key);
  assign sel   = wr.claim ? cand_r : hit_r;

  always_comb begin
    tok_nxt.valid = tok_in.valid;
    tok_nxt.hit   = tok_in.hit | match;
    tok_nxt.free  = tok_in.free | ~occ;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      tok_r   <= '0;
      hit_r   <= 1'b0;
      cand_r  <= 1'b0;
    end else begin
      if (tok_in.valid) begin
        tok_r  <= tok_nxt;
        hit_r  <= match;
        cand_r <= ~occ & ~tok_in.free;
      end else begin
        tok_r.valid <= 1'b0;
      end
      if (wr.en && sel) begin
        count_r <= wr_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      tcnt_r <= match ? count_r : tcnt_in;
    end
    if (wr.en && wr.claim && cand_r) begin
      key_r <= wr_key;
    end
  end

  assign tok_out  = tok_r;
  assign tcnt_out = tcnt_r;

endmodule

>>> design/counting_multiset_table.sv
// counting multiset table top level: item register, cell chain, result logic
// a taken word is registered, its search token walks every cell, the chain tail is captured in
// result registers, then the output register is loaded once it is empty or being read;
// the next word is taken after that load, while the result still waits in the output register
// reset clears every slot count (all slots free); slot keys are left unset, no clearing pass
module counting_multiset_table import cmst_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_kind,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic [AMOUNT_W-1:0] in_amount,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [NCOUNT_W-1:0] out_new_count,
  output logic [1:0]          out_status
);

  localparam int WIDE     = (COUNT_BITS > AMOUNT_W) ? COUNT_BITS : AMOUNT_W;
  localparam int SUM_BITS = WIDE + 1;
  localparam logic [SUM_BITS-1:0] COUNT_MAX =
    {{(SUM_BITS-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic                  start_r;
  logic                  kind_r;
  logic [KEY_BITS-1:0]   item_key_r;
  logic [KEY_BITS-1:0]   key_ext;
  logic [AMOUNT_W-1:0]   amount_r;
  logic                  res_hit_r;
  logic                  res_free_r;
  logic [COUNT_BITS-1:0] old_cnt_r;
  logic                  out_valid_r;
  logic [NCOUNT_W-1:0]   out_new_count_r;
  status_t               out_status_r;

  tok_t                  tok_c  [0:SLOTS];
  logic [COUNT_BITS-1:0] tcnt_c [0:SLOTS];

  logic                  accept;
  logic                  fire;
  logic [COUNT_BITS-1:0] base;
  logic [SUM_BITS-1:0]   base_ext;
  logic [SUM_BITS-1:0]   amt_ext;
  logic [SUM_BITS-1:0]   sum;
  logic [SUM_BITS-1:0]   diff;
  logic                  sat;
  logic [COUNT_BITS-1:0] add_cnt;
  logic [COUNT_BITS-1:0] rem_cnt;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [NCOUNT_W-1:0]   new_cnt_out;
  status_t               st;
  logic                  do_wr;
  logic                  do_claim;
  wr_t                   wr;

  generate
    if (KEY_BITS > KEY_W) begin : g_key_wide
      assign key_ext = {{(KEY_BITS-KEY_W){1'b0}}, in_key[KEY_W-1:0]};
    end else begin : g_key_narrow
      assign key_ext = in_key[KEY_BITS-1:0];
    end
    if (COUNT_BITS < NCOUNT_W) begin : g_cnt_narrow
      assign new_cnt_out = {{(NCOUNT_W-COUNT_BITS){1'b0}}, new_cnt};
    end else begin : g_cnt_wide
      assign new_cnt_out = new_cnt[NCOUNT_W-1:0];
    end
  endgenerate

  assign accept = in_valid && in_ready;
  assign fire   = (state_r == S_WAIT) && (!out_valid_r || out_ready);

  // search chain
  assign tok_c[0]  = '{valid: start_r, hit: 1'b0, free: 1'b0};
  assign tcnt_c[0] = '0;

  generate
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      cmst_cell #(
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_key (item_key_r),
        .tok_in   (tok_c[i]),
        .tcnt_in  (tcnt_c[i]),
        .tok_out  (tok_c[i+1]),
        .tcnt_out (tcnt_c[i+1]),
        .wr       (wr),
        .wr_key   (item_key_r),
        .wr_count (new_cnt)
      );
    end
  endgenerate

  // result arithmetic
  always_comb begin
    base     = res_hit_r ? old_cnt_r : '0;
    base_ext = {{(SUM_BITS-COUNT_BITS){1'b0}}, base};
    amt_ext  = {{(SUM_BITS-AMOUNT_W){1'b0}}, amount_r};
    sum      = base_ext + amt_ext;
    diff     = base_ext - amt_ext;
    sat      = (sum > COUNT_MAX);
    add_cnt  = sat ? COUNT_MAX[COUNT_BITS-1:0] : sum[COUNT_BITS-1:0];
    rem_cnt  = (amt_ext >= base_ext) ? '0 : diff[COUNT_BITS-1:0];
    do_wr    = 1'b0;
    do_claim = 1'b0;
    new_cnt  = '0;
    st       = ST_OK;
    case (kind_r)
      KIND_ADD: begin
        if (res_hit_r) begin
          do_wr   = 1'b1;
          new_cnt = add_cnt;
          st      = sat ? ST_SAT : ST_OK;
        end else if (amount_r == '0) begin
          st = ST_OK;
        end else if (res_free_r) begin
          do_wr    = 1'b1;
          do_claim = 1'b1;
          new_cnt  = add_cnt;
          st       = sat ? ST_SAT : ST_OK;
        end else begin
          st = ST_FULL;
        end
      end
      KIND_REM: begin
        if (res_hit_r) begin
          do_wr   = 1'b1;
          new_cnt = rem_cnt;
        end else begin
          st = ST_ABSENT;
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  assign wr.en    = fire && do_wr;
  assign wr.claim = do_claim;

  // control fsm
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_WALK;
      S_WALK: if (tok_c[SLOTS].valid) state_nxt = S_WAIT;
      S_WAIT: if (fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= accept;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r     <= in_kind;
      item_key_r <= key_ext;
      amount_r   <= in_amount;
    end
    if ((state_r == S_WALK) && tok_c[SLOTS].valid) begin
      res_hit_r  <= tok_c[SLOTS].hit;
      res_free_r <= tok_c[SLOTS].free;
      old_cnt_r  <= tcnt_c[SLOTS];
    end
    if (fire) begin
      out_new_count_r <= new_cnt_out;
      out_status_r    <= st;
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_new_count = out_new_count_r;
  assign out_status    = out_status_r;

  a_tail_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    tok_c[SLOTS].valid |-> (state_r == S_WALK))
    else $error("search token left the chain outside a walk");

  a_start_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (start_r && (state_r == S_WALK)))
    else $error("taken word did not launch a search");

  a_rise_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_WAIT))
    else $error("result word raised outside the wait state");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ((st == ST_FULL) || (st == ST_ABSENT))) |-> !wr.en)
    else $error("table written on a dropped word");

endmodule

>>> tb/testbench.sv
// self-checking testbench for the counting multiset table, with its own table predictor
`timescale 1ns / 100ps

module testbench;
  import cmst_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 4 * (SLOTS_DEF + 2);
  localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS_DEF) - 33'd1;

  typedef struct {
    logic [NCOUNT_W-1:0] count;
    status_t             status;
  } tally_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_kind;
  logic signed [KEY_W-1:0]    in_key;
  logic [AMOUNT_W-1:0]        in_amount;
  logic                       out_valid;
  logic                       out_ready;
  logic [NCOUNT_W-1:0]        out_new_count;
  logic [1:0]                 out_status;

  logic [KEY_BITS_DEF-1:0]    held_key [SLOTS_DEF];
  logic [COUNT_BITS_DEF-1:0]  held_count [SLOTS_DEF];
  tally_t                     pending_tallies [$];
  int                         fail_count;
  int                         cycle_count;
  int                         in_idle_pct;
  int                         out_idle_pct;

  counting_multiset_table u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_key       (in_key),
    .in_amount    (in_amount),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_new_count(out_new_count),
    .out_status   (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // applies one word to the table copy and returns the count and status it yields
  function automatic tally_t tally_update(input logic kind, input logic [KEY_W-1:0] key,
                                          input logic [AMOUNT_W-1:0] amount);
    tally_t                  res;
    int                      slot;
    int                      free_slot;
    int                      i;
    logic [32:0]             sum;
    logic [KEY_BITS_DEF-1:0] k;
    k = key[KEY_BITS_DEF-1:0];
    res.count = '0;
    res.status = ST_OK;
    slot = -1;
    free_slot = -1;
    for (i = SLOTS_DEF - 1; i >= 0; i--) begin
      if (held_count[i] != '0 && held_key[i] == k) slot = i;
      if (held_count[i] == '0) free_slot = i;
    end
    if (kind == KIND_ADD) begin
      if (slot < 0 && amount != '0) begin
        if (free_slot < 0) begin
          res.status = ST_FULL;
        end else begin
          held_key[free_slot] = k;
          held_count[free_slot] = '0;
          slot = free_slot;
        end
      end
      if (slot >= 0 && res.status == ST_OK) begin
        sum = 33'(held_count[slot]) + 33'(amount);
        if (sum > COUNT_MAX) begin
          sum = COUNT_MAX;
          res.status = ST_SAT;
        end
        held_count[slot] = sum[COUNT_BITS_DEF-1:0];
        res.count = sum[NCOUNT_W-1:0];
      end
    end else begin
      if (slot < 0) begin
        res.status = ST_ABSENT;
      end else if (33'(amount) >= 33'(held_count[slot])) begin
        held_count[slot] = '0;
      end else begin
        held_count[slot] = held_count[slot] - COUNT_BITS_DEF'(amount);
        res.count = NCOUNT_W'(held_count[slot]);
      end
    end
    return res;
  endfunction

  task automatic send_word(input logic kind, input logic [KEY_W-1:0] key,
                           input logic [AMOUNT_W-1:0] amount);
    int gap;
    gap = ($urandom_range(0, 99) < in_idle_pct) ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_key    <= key;
    in_amount <= amount;
    do @(posedge clk); while (!in_ready);
    pending_tallies.push_back(tally_update(kind, key, amount));
  endtask

  // result side: random stall before each word
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = ($urandom_range(0, 99) < out_idle_pct) ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin : check_words
    tally_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_tallies.size() == 0) begin
        $error("unexpected result word: new_count %0d status %0d", out_new_count, out_status);
        fail_count++;
      end else begin
        want = pending_tallies.pop_front();
        if (out_new_count !== want.count) begin
          $error("new_count: expected %0d, got %0d", want.count, out_new_count);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
      end
    end
  end

  task automatic test_add_paths();
    send_word(KIND_ADD, 32'h8000_0000, 16'hFFFF);
    send_word(KIND_ADD, 32'h8000_0000, 16'h0001);
    send_word(KIND_ADD, 32'h7FFF_FFFF, 16'h0000);
    send_word(KIND_ADD, 32'h7FFF_FFFF, 16'h000A);
    send_word(KIND_ADD, 32'h7FFF_FFFF, 16'h0000);
    send_word(KIND_ADD, 32'h0000_0000, 16'h0001);
  endtask

  task automatic test_remove_paths();
    send_word(KIND_REM, 32'h1234_5678, 16'h0005);
    send_word(KIND_REM, 32'h7FFF_FFFF, 16'h0003);
    send_word(KIND_REM, 32'h7FFF_FFFF, 16'h0000);
    send_word(KIND_REM, 32'h7FFF_FFFF, 16'hFFFF);
    send_word(KIND_REM, 32'h0000_0000, 16'h0001);
  endtask

  task automatic test_table_full();
    int n;
    send_word(KIND_ADD, 32'hFFFF_FFFF, 16'h0004);
    for (n = 1; n < SLOTS_DEF - 1; n++) send_word(KIND_ADD, KEY_W'(n), 16'h0001);
    send_word(KIND_ADD, 32'h5555_5555, 16'h0003);
    send_word(KIND_ADD, 32'h0000_0003, 16'h0001);
    send_word(KIND_REM, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(KIND_ADD, 32'hAAAA_AAAA, 16'h0002);
  endtask

  // pool of live keys plus fresh ones, with some stray keys mixed in
  task automatic test_random_traffic(input int words, input int pool_size,
                                     input int pct_in, input int pct_out);
    logic [KEY_W-1:0]    pool [$];
    logic [KEY_W-1:0]    key;
    logic                kind;
    logic [AMOUNT_W-1:0] amount;
    int                  pick;
    int                  i;
    in_idle_pct = pct_in;
    out_idle_pct = pct_out;
    for (i = 0; i < SLOTS_DEF; i++) begin
      if (held_count[i] != '0) pool.push_back(held_key[i]);
    end
    while (pool.size() < pool_size) pool.push_back($urandom);
    repeat (words) begin
      pick = $urandom_range(0, 99);
      key = (pick < 10) ? KEY_W'($urandom) : pool[$urandom_range(0, pool.size() - 1)];
      kind = ($urandom_range(0, 99) < 55) ? KIND_ADD : KIND_REM;
      pick = $urandom_range(0, 99);
      if (pick < 5) amount = '0;
      else if (pick < 55) amount = AMOUNT_W'($urandom_range(1, 8));
      else if (pick < 90) amount = AMOUNT_W'($urandom);
      else amount = '1;
      send_word(kind, key, amount);
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_kind     <= KIND_ADD;
    in_key      <= '0;
    in_amount   <= '0;
    fail_count  = 0;
    cycle_count = 0;
    in_idle_pct = 50;
    out_idle_pct = 50;
    for (int i = 0; i < SLOTS_DEF; i++) begin
      held_key[i] = '0;
      held_count[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_add_paths();
    test_remove_paths();
    test_table_full();
    test_random_traffic(300, 6, 0, 0);
    test_random_traffic(400, 20, 50, 50);
    test_random_traffic(300, 40, 100, 0);
    test_random_traffic(350, 12, 0, 100);
    test_random_traffic(400, 24, 100, 100);
    in_valid <= 1'b0;

    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
design/cmst_pkg.sv
design/cmst_cell.sv
design/counting_multiset_table.sv
tb/testbench.sv
